>>> hdl/pol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ELEM_W   = 8;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

>>> hdl/positional_ordered_list_unit.sv
// Ordered list of up to CAPACITY byte elements, addressed by 1-based position.
// Input channel (in_valid_i/in_ready_o) carries action, position and value;
// output channel (out_valid_o/out_ready_i) carries one result per transfer:
// ok, read_value, found_position, length and empty_res.
// Elements live in a synchronous RAM with one read and one write port and
// registered read data. Each element moved or examined takes an S_RD and
// an S_WR state (read, then write-back or compare). The next item can be
// accepted in the cycle after the result is loaded into the output register.
// Insert shifts elements back from the tail and then writes the new value;
// delete moves the later elements forward; locate compares from the head.
// Items are handled one at a time; in_ready_o is high whenever no item is in
// progress, even while a result waits in the output register.
// If the receiver stalls, the finished result of the next item waits inside
// until the output register is free, and no further item is accepted.
// Reset clears the element count and the output valid; the RAM is not
// cleared, as entries beyond the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_unit
  import pol_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [POS_W-1:0] position_i,
  input  wire logic [VAL_W-1:0] value_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  ok_o,
  output logic      [VAL_W-1:0] read_value_o,
  output logic      [POS_W-1:0] found_position_o,
  output logic      [POS_W-1:0] length_o,
  output logic                  empty_res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PUT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  slot_q, slot_d;
  action_e           act_q, act_d;
  logic [ELEM_W-1:0] val_q, val_d;
  logic              ok_q, ok_d;
  logic [ELEM_W-1:0] rd_q, rd_d;
  logic [POS_W-1:0]  found_q, found_d;

  logic              out_valid_q;
  logic              out_ok_q;
  logic [VAL_W-1:0]  out_rd_q;
  logic [POS_W-1:0]  out_found_q;
  logic [CNT_W-1:0]  out_len_q;

  ram_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [ELEM_W-1:0] ram_rd_data;

  logic              in_xfer;
  logic              load;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              pos_nz;
  logic              ins_ok;
  logic              acc_ok;
  logic [CNT_W-1:0]  slot_new;
  logic [CNT_W-1:0]  ptr_inc;
  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  cnt_last;

  pol_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load       = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign pos_nz   = (position_i != '0);
  assign ins_ok   = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1)) &&
                    (cnt_ext < CMP_W'(CAPACITY));
  assign acc_ok   = pos_nz && (pos_ext <= cnt_ext);
  assign slot_new = CNT_W'(position_i - POS_W'(1));
  assign ptr_inc  = ptr_q + CNT_W'(1);
  assign ptr_dec  = ptr_q - CNT_W'(1);
  assign cnt_last = count_q - CNT_W'(1);

  assign ram_rd_addr = ptr_q[ADDR_W-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    slot_d  = slot_q;
    act_d   = act_q;
    val_d   = val_q;
    ok_d    = ok_q;
    rd_d    = rd_q;
    found_d = found_q;
    ram_wr  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          act_d   = action_e'(action_i);
          val_d   = ELEM_W'(value_i);
          slot_d  = slot_new;
          ok_d    = 1'b0;
          rd_d    = '0;
          found_d = '0;
          case (action_e'(action_i))
            ACT_INSERT: begin
              if (!ins_ok) begin
                state_d = S_OUT;
              end else if (count_q == slot_new) begin
                state_d = S_PUT;
              end else begin
                ptr_d   = cnt_last;
                state_d = S_RD;
              end
            end
            ACT_DELETE, ACT_GET: begin
              if (!acc_ok) begin
                state_d = S_OUT;
              end else begin
                ptr_d   = slot_new;
                state_d = S_RD;
              end
            end
            ACT_LOCATE: begin
              ptr_d   = '0;
              state_d = (count_q == '0) ? S_OUT : S_RD;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        case (act_q)
          ACT_INSERT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = ptr_inc[ADDR_W-1:0];
            ram_wr.data = ram_rd_data;
            if (ptr_q == slot_q) begin
              state_d = S_PUT;
            end else begin
              ptr_d   = ptr_dec;
              state_d = S_RD;
            end
          end
          ACT_DELETE: begin
            if (ptr_q == slot_q) begin
              rd_d = ram_rd_data;
            end else begin
              ram_wr.en   = 1'b1;
              ram_wr.addr = ptr_dec[ADDR_W-1:0];
              ram_wr.data = ram_rd_data;
            end
            if (ptr_q == cnt_last) begin
              ok_d    = 1'b1;
              state_d = S_OUT;
            end else begin
              ptr_d   = ptr_inc;
              state_d = S_RD;
            end
          end
          ACT_GET: begin
            rd_d    = ram_rd_data;
            ok_d    = 1'b1;
            state_d = S_OUT;
          end
          ACT_LOCATE: begin
            if (ram_rd_data == val_q) begin
              found_d = POS_W'(ptr_inc);
              ok_d    = 1'b1;
              state_d = S_OUT;
            end else if (ptr_q == cnt_last) begin
              state_d = S_OUT;
            end else begin
              ptr_d   = ptr_inc;
              state_d = S_RD;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_PUT: begin
        ram_wr.en   = 1'b1;
        ram_wr.addr = slot_q[ADDR_W-1:0];
        ram_wr.data = val_q;
        ok_d        = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          if (ok_q && (act_q == ACT_INSERT)) begin
            count_d = count_q + CNT_W'(1);
          end else if (ok_q && (act_q == ACT_DELETE)) begin
            count_d = cnt_last;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    slot_q  <= slot_d;
    act_q   <= act_d;
    val_q   <= val_d;
    ok_q    <= ok_d;
    rd_q    <= rd_d;
    found_q <= found_d;
    if (load) begin
      out_ok_q    <= ok_q;
      out_rd_q    <= VAL_W'(rd_q);
      out_found_q <= found_q;
      out_len_q   <= count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign read_value_o     = out_rd_q;
  assign found_position_o = out_found_q;
  assign length_o         = POS_W'(out_len_q);
  assign empty_res_o      = (out_len_q == '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("element count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !ok_q) |=> (count_q == $past(count_q)))
    else $error("failed operation changed the element count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.en |-> (state_q != S_IDLE) && (CMP_W'(ram_wr.addr) <= CMP_W'(count_q)))
    else $error("memory write outside an operation or beyond the list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("result dropped while the output register was held");

endmodule

`default_nettype wire

>>> hdl/pol_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pol_ram
  import pol_pkg::*;
(
  input  wire logic              clk_i,
  input  wire ram_wr_t           wr_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [ELEM_W-1:0] rd_data_o
);

  logic [ELEM_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire
